// ===== hdl/brb_pkg.sv =====
package brb_pkg;

    // field widths of the stream items
    localparam int REQ_W    = 3;
    localparam int DATA_W   = 8;
    localparam int LEN_W    = 7;
    localparam int STAT_W   = 2;
    localparam int USED_W   = 10;
    localparam int FREE_W   = 10;
    localparam int CFREE_W  = 11;
    localparam int CUSED_W  = 10;

    // packed stream widths
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 56;

    // largest message or read length that is served
    localparam int MAX_LEN = 64;

    // message byte offset saturates here
    localparam logic [LEN_W-1:0] OFFSET_MAX = 7'd127;

    // number of distinct length codes
    localparam int LEN_CNT = 2 ** LEN_W;

    // request codes
    localparam logic [REQ_W-1:0] REQ_WRITE  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_READ   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PEEK   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_COMMIT = 3'd4;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd5;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_DATA  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_SPACE = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic cap;        // capture the input transfer
        logic exec;       // apply the captured request
        logic load;       // load the output register
        logic load_byte;  // output carries a stored byte
        logic next_byte;  // issue the next store read
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic stream;     // request delivers stored bytes
        logic last_byte;  // byte in flight is the final one
    } t_stat;

endpackage

// ===== hdl/byte_ring_buffer.sv =====
// Circular byte store of SLOTS entries with one entry always left empty, so at
// most SLOTS-1 bytes are held. Each input transfer is one request: a write byte
// (messages are accepted or refused whole on their first byte and committed on
// the byte marked last), read, peek, remove, commit write or clear. Write,
// remove, commit, clear and refused or empty reads give one result each; a
// read or peek of N bytes gives N results, one byte per cycle out of the
// registered read port of the store while the receiver takes each one. Every
// result carries the used, free and contiguous sizes after the request. A
// result waits in the output register while the next request is taken in.
module byte_ring_buffer
    import brb_pkg::*;
#(
    parameter int SLOTS = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // data_in[7:0], length[14:8], zero pad
    input  logic [REQ_W-1:0]       i_s_axis_tuser,   // req_type[2:0]
    input  logic                   i_s_axis_tlast,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // data_out[7:0], used_bytes[17:8],
                                                     // free_bytes[27:18],
                                                     // contig_free[38:28],
                                                     // contig_used[48:39], zero pad
    output logic [STAT_W-1:0]      o_m_axis_tuser,   // status[1:0]
    output logic                   o_m_axis_tlast
);

    localparam int OUT_USED_W = DATA_W + USED_W + FREE_W + CFREE_W + CUSED_W;

    t_cmd               w_cmd;
    t_stat              w_stat;
    logic [DATA_W-1:0]  w_data_out;
    logic [USED_W-1:0]  w_used;
    logic [FREE_W-1:0]  w_free;
    logic [CFREE_W-1:0] w_cf;
    logic [CUSED_W-1:0] w_cu;

    // handshake sequencing
    brb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // store, positions and result fields
    brb_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_req_type    (i_s_axis_tuser),
        .i_data_in     (i_s_axis_tdata[DATA_W-1:0]),
        .i_length      (i_s_axis_tdata[DATA_W +: LEN_W]),
        .i_last_in     (i_s_axis_tlast),
        .o_status      (o_m_axis_tuser),
        .o_data_out    (w_data_out),
        .o_last_out    (o_m_axis_tlast),
        .o_used_bytes  (w_used),
        .o_free_bytes  (w_free),
        .o_contig_free (w_cf),
        .o_contig_used (w_cu)
    );

    // result packing, lowest field first
    assign o_m_axis_tdata = {{(OUT_TDATA_W - OUT_USED_W){1'b0}},
                             w_cu, w_cf, w_free, w_used, w_data_out};

endmodule

// ===== hdl/brb_ram.sv =====
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/brb_ctrl.sv =====
module brb_ctrl
    import brb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    output logic  o_m_tvalid,
    input  logic  i_m_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP,
        S_RD_DATA
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_s_ready;
    logic   n_s_ready;
    logic   r_m_valid;
    logic   n_m_valid;
    logic   w_out_free;

    // output register can take a result this cycle
    assign w_out_free = !r_m_valid || i_m_tready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.stream ? S_RD_DATA : S_RESP;
            end
            S_RESP: begin
                if (w_out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_RD_DATA: begin
                if (w_out_free) begin
                    o_cmd.load      = 1'b1;
                    o_cmd.load_byte = 1'b1;
                    if (i_stat.last_byte) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.next_byte = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result valid holds until its transfer
    assign n_m_valid = o_cmd.load || (r_m_valid && !i_m_tready);
    assign n_s_ready = (n_state == S_IDLE);

    // state and registered handshake outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_s_ready <= 1'b1;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_s_ready <= n_s_ready;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_s_tready = r_s_ready;
    assign o_m_tvalid = r_m_valid;

endmodule

// ===== hdl/brb_dp.sv =====
module brb_dp
    import brb_pkg::*;
#(
    parameter int SLOTS = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic [DATA_W-1:0]   i_data_in,
    input  logic [LEN_W-1:0]    i_length,
    input  logic                i_last_in,
    output logic [STAT_W-1:0]   o_status,
    output logic [DATA_W-1:0]   o_data_out,
    output logic                o_last_out,
    output logic [USED_W-1:0]   o_used_bytes,
    output logic [FREE_W-1:0]   o_free_bytes,
    output logic [CFREE_W-1:0]  o_contig_free,
    output logic [CUSED_W-1:0]  o_contig_used
);

    localparam int PW = $clog2(SLOTS);
    localparam int SW = PW + 1;
    localparam logic [SW-1:0] SLOTS_W = SW'(SLOTS);
    localparam logic [PW-1:0] POS_LAST = PW'(SLOTS - 1);

    // captured request
    logic [REQ_W-1:0]  r_req_type;
    logic [DATA_W-1:0] r_data;
    logic [LEN_W-1:0]  r_len;
    logic              r_last;

    // positions and message state
    logic [PW-1:0]     r_rd_pos,  n_rd_pos;
    logic [PW-1:0]     r_wr_pos,  n_wr_pos;
    logic [LEN_W-1:0]  r_msg_offset, n_msg_offset;
    logic              r_msg_rej, n_msg_rej;
    logic [LEN_W-1:0]  r_msg_len, n_msg_len;
    logic [PW-1:0]     r_msg_addr, n_msg_addr;

    // read stream
    logic [PW-1:0]     r_strm_addr, n_strm_addr;
    logic [LEN_W-1:0]  r_strm_cnt, n_strm_cnt;
    logic [STAT_W-1:0] r_status, n_status;

    // output register
    logic [STAT_W-1:0]  r_out_status;
    logic [DATA_W-1:0]  r_out_data;
    logic               r_out_last;
    logic [USED_W-1:0]  r_out_used;
    logic [FREE_W-1:0]  r_out_free;
    logic [CFREE_W-1:0] r_out_cf;
    logic [CUSED_W-1:0] r_out_cu;

    logic [SW-1:0]     w_used, w_free, w_cf, w_cu;
    logic [31:0]       w_used32, w_free32, w_cf32, w_cu32;
    logic              w_is_write, w_is_rdpk, w_first, w_rej, w_rd_fail;
    logic [LEN_W-1:0]  w_len_m, w_tbl_idx;
    logic [PW-1:0]     w_wr_addr, w_adv_w, w_adv_r;
    logic [PW-1:0]     w_len_mod [LEN_CNT];
    logic              w_ram_we, w_ram_re;
    logic [PW-1:0]     w_ram_raddr;
    logic [DATA_W-1:0] w_rd_data;

    // position plus a reduced length, one wrap at most
    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] pos,
                                               input logic [PW-1:0] by);
        logic [SW-1:0] sum;
        sum = SW'(pos) + SW'(by);
        if (sum >= SLOTS_W) begin
            sum = sum - SLOTS_W;
        end
        return sum[PW-1:0];
    endfunction

    // step one entry forward with wrap
    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] pos);
        return (pos == POS_LAST) ? '0 : pos + 1'b1;
    endfunction

    // length codes reduced modulo the slot count
    for (genvar g = 0; g < LEN_CNT; g++) begin : g_len_mod
        assign w_len_mod[g] = PW'(g % SLOTS);
    end

    // occupancy figures from the current positions
    always_comb begin
        if (r_wr_pos >= r_rd_pos) begin
            w_used = SW'(r_wr_pos) - SW'(r_rd_pos);
            w_cf   = SLOTS_W - SW'(r_wr_pos);
        end else begin
            w_used = SLOTS_W - SW'(r_rd_pos) + SW'(r_wr_pos);
            w_cf   = SW'(r_rd_pos) - SW'(r_wr_pos) - SW'(1);
        end
        if (r_rd_pos > r_wr_pos) begin
            w_cu = SLOTS_W - SW'(r_rd_pos);
        end else begin
            w_cu = SW'(r_wr_pos) - SW'(r_rd_pos);
        end
        w_free = SLOTS_W - w_used - SW'(1);
    end

    assign w_used32 = 32'(w_used);
    assign w_free32 = 32'(w_free);
    assign w_cf32   = 32'(w_cf);
    assign w_cu32   = 32'(w_cu);

    // request decode and checks
    assign w_is_write = (r_req_type == REQ_WRITE);
    assign w_is_rdpk  = (r_req_type == REQ_READ) || (r_req_type == REQ_PEEK);
    assign w_first    = (r_msg_offset == '0);
    assign w_len_m    = w_first ? r_len : r_msg_len;
    assign w_rej      = w_first ? ((32'(r_len) > 32'(MAX_LEN)) || (32'(r_len) > w_free32))
                                : r_msg_rej;
    assign w_rd_fail  = (32'(r_len) > 32'(MAX_LEN)) || (32'(r_len) > w_used32);
    assign w_wr_addr  = w_first ? r_wr_pos : r_msg_addr;
    assign w_tbl_idx  = w_is_write ? w_len_m : r_len;
    assign w_adv_w    = wrap_add(r_wr_pos, w_len_mod[w_tbl_idx]);
    assign w_adv_r    = wrap_add(r_rd_pos, w_len_mod[w_tbl_idx]);

    assign o_stat.stream    = w_is_rdpk && !w_rd_fail && (r_len != '0);
    assign o_stat.last_byte = (r_strm_cnt == LEN_W'(1));

    assign w_ram_we = i_cmd.exec && w_is_write && !w_rej && (r_msg_offset < w_len_m);

    // request execution and stream stepping
    always_comb begin
        n_rd_pos     = r_rd_pos;
        n_wr_pos     = r_wr_pos;
        n_msg_offset = r_msg_offset;
        n_msg_rej    = r_msg_rej;
        n_msg_len    = r_msg_len;
        n_msg_addr   = r_msg_addr;
        n_strm_addr  = r_strm_addr;
        n_strm_cnt   = r_strm_cnt;
        n_status     = r_status;
        w_ram_re     = 1'b0;
        w_ram_raddr  = r_strm_addr;
        if (i_cmd.exec) begin
            if (w_is_write) begin
                n_status     = w_rej ? ST_NO_SPACE : ST_OK;
                n_msg_offset = (r_msg_offset < OFFSET_MAX) ? r_msg_offset + 1'b1
                                                           : r_msg_offset;
                n_msg_rej    = w_rej;
                n_msg_len    = w_len_m;
                n_msg_addr   = wrap_inc(w_wr_addr);
                if (r_last) begin
                    if (!w_rej) begin
                        n_wr_pos = w_adv_w;
                    end
                    n_msg_offset = '0;
                    n_msg_rej    = 1'b0;
                    n_msg_len    = '0;
                end
            end else begin
                // any other request drops a message in progress
                n_msg_offset = '0;
                n_msg_rej    = 1'b0;
                n_msg_len    = '0;
                n_status     = (w_is_rdpk && w_rd_fail) ? ST_NO_DATA : ST_OK;
                if (o_stat.stream) begin
                    w_ram_re    = 1'b1;
                    w_ram_raddr = r_rd_pos;
                    n_strm_addr = wrap_inc(r_rd_pos);
                    n_strm_cnt  = r_len;
                end
                case (r_req_type)
                    REQ_READ: begin
                        if (o_stat.stream) begin
                            n_rd_pos = w_adv_r;
                        end
                    end
                    REQ_REMOVE: begin
                        n_rd_pos = w_adv_r;
                    end
                    REQ_COMMIT: begin
                        n_wr_pos = w_adv_w;
                    end
                    REQ_CLEAR: begin
                        n_rd_pos = '0;
                        n_wr_pos = '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
        if (i_cmd.load && i_cmd.load_byte) begin
            n_strm_cnt = r_strm_cnt - 1'b1;
        end
        if (i_cmd.next_byte) begin
            w_ram_re    = 1'b1;
            w_ram_raddr = r_strm_addr;
            n_strm_addr = wrap_inc(r_strm_addr);
        end
    end

    // byte store
    brb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SLOTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_we),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (r_data),
        .i_rd_en   (w_ram_re),
        .i_rd_addr (w_ram_raddr),
        .o_rd_data (w_rd_data)
    );

    // positions and message state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pos     <= '0;
            r_wr_pos     <= '0;
            r_msg_offset <= '0;
            r_msg_rej    <= 1'b0;
            r_msg_len    <= '0;
        end else begin
            r_rd_pos     <= n_rd_pos;
            r_wr_pos     <= n_wr_pos;
            r_msg_offset <= n_msg_offset;
            r_msg_rej    <= n_msg_rej;
            r_msg_len    <= n_msg_len;
        end
    end

    // request capture, stream registers and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_req_type <= i_req_type;
            r_data     <= i_data_in;
            r_len      <= i_length;
            r_last     <= i_last_in;
        end
        r_msg_addr  <= n_msg_addr;
        r_strm_addr <= n_strm_addr;
        r_strm_cnt  <= n_strm_cnt;
        r_status    <= n_status;
        if (i_cmd.load) begin
            r_out_status <= i_cmd.load_byte ? ST_OK : r_status;
            r_out_data   <= i_cmd.load_byte ? w_rd_data : '0;
            r_out_last   <= i_cmd.load_byte ? o_stat.last_byte : 1'b1;
            r_out_used   <= w_used32[USED_W-1:0];
            r_out_free   <= w_free32[FREE_W-1:0];
            r_out_cf     <= w_cf32[CFREE_W-1:0];
            r_out_cu     <= w_cu32[CUSED_W-1:0];
        end
    end

    assign o_status      = r_out_status;
    assign o_data_out    = r_out_data;
    assign o_last_out    = r_out_last;
    assign o_used_bytes  = r_out_used;
    assign o_free_bytes  = r_out_free;
    assign o_contig_free = r_out_cf;
    assign o_contig_used = r_out_cu;

endmodule

// ===== sim/byte_ring_buffer_test.sv =====
`timescale 1ns / 1ps

module byte_ring_buffer_test;
    import brb_pkg::*;

    localparam int RING_SLOTS     = 1024;
    localparam int SLOT_AW        = $clog2(RING_SLOTS);
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    // request codes the block treats as no-ops, apart from ending a message in progress
    localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;

    // one result transfer, fields in output order
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [DATA_W-1:0]  data;
        logic               last;
        logic [USED_W-1:0]  used;
        logic [FREE_W-1:0]  free;
        logic [CFREE_W-1:0] cfree;
        logic [CUSED_W-1:0] cused;
    } t_ring_result;

    // mirror of the ring: positions, message state and the results each request is due to give
    class t_ring_mirror;
        logic [DATA_W-1:0] mem [RING_SLOTS];
        bit                written [RING_SLOTS];
        int unsigned       rd_pos;
        int unsigned       wr_pos;
        int unsigned       msg_off;
        int unsigned       msg_len;
        bit                msg_rej;
        t_ring_result      due_results [$];
        int unsigned       n_errors;
        int unsigned       n_checked;
        int unsigned       n_requests;
        int unsigned       n_no_space;
        int unsigned       n_no_data;

        function int unsigned used_size();
            return (wr_pos >= rd_pos) ? wr_pos - rd_pos : RING_SLOTS - rd_pos + wr_pos;
        endfunction

        function int unsigned free_size();
            return RING_SLOTS - used_size() - 1;
        endfunction

        function void push_result(logic [STAT_W-1:0] status, logic [DATA_W-1:0] data,
                                  logic last);
            t_ring_result r;
            r.status = status;
            r.data   = data;
            r.last   = last;
            r.used   = USED_W'(used_size());
            r.free   = FREE_W'(free_size());
            r.cfree  = CFREE_W'((wr_pos >= rd_pos) ? RING_SLOTS - wr_pos
                                                   : rd_pos - wr_pos - 1);
            r.cused  = CUSED_W'((rd_pos > wr_pos) ? RING_SLOTS - rd_pos : wr_pos - rd_pos);
            due_results.push_back(r);
        endfunction

        // apply one accepted request and queue the results it gives
        function void apply_request(logic [REQ_W-1:0] req, logic [DATA_W-1:0] data,
                                    logic [LEN_W-1:0] len, logic last_flag);
            logic [STAT_W-1:0]  stat;
            logic [SLOT_AW-1:0] idx;
            int unsigned        start;
            int unsigned        k;
            n_requests++;
            if (req == REQ_WRITE) begin
                // first byte of a message decides accept or refuse
                if (msg_off == 0) begin
                    msg_len = len;
                    msg_rej = (len > MAX_LEN) || (len > free_size());
                end
                if (!msg_rej && msg_off < msg_len) begin
                    idx = SLOT_AW'((wr_pos + msg_off) % RING_SLOTS);
                    mem[idx] = data;
                    written[idx] = 1'b1;
                end
                if (msg_off < OFFSET_MAX)
                    msg_off++;
                stat = msg_rej ? ST_NO_SPACE : ST_OK;
                if (msg_rej)
                    n_no_space++;
                if (last_flag) begin
                    if (!msg_rej)
                        wr_pos = (wr_pos + msg_len) % RING_SLOTS;
                    msg_off = 0;
                    msg_rej = 1'b0;
                    msg_len = 0;
                end
                push_result(stat, '0, 1'b1);
                return;
            end

            // any other request abandons a message in progress
            msg_off = 0;
            msg_rej = 1'b0;
            msg_len = 0;

            if (req == REQ_READ || req == REQ_PEEK) begin
                if (len > MAX_LEN || len > used_size()) begin
                    n_no_data++;
                    push_result(ST_NO_DATA, '0, 1'b1);
                end else if (len == 0) begin
                    push_result(ST_OK, '0, 1'b1);
                end else begin
                    start = rd_pos;
                    if (req == REQ_READ)
                        rd_pos = (rd_pos + len) % RING_SLOTS;
                    for (k = 0; k < len; k++)
                        push_result(ST_OK, mem[SLOT_AW'((start + k) % RING_SLOTS)],
                                    (k + 1 == len));
                end
                return;
            end

            // position moves, unchecked
            case (req)
                REQ_REMOVE: begin
                    rd_pos = (rd_pos + len) % RING_SLOTS;
                end
                REQ_COMMIT: begin
                    wr_pos = (wr_pos + len) % RING_SLOTS;
                end
                REQ_CLEAR: begin
                    rd_pos = 0;
                    wr_pos = 0;
                end
                default: begin
                end
            endcase
            push_result(ST_OK, '0, 1'b1);
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                n_errors++;
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            end
        endfunction

        // compare one result transfer with the oldest one due
        function void compare_result(t_ring_result got);
            t_ring_result want;
            if (due_results.size() == 0) begin
                n_errors++;
                $display("%0t: result with nothing due, expected none actual status %0d data %0d",
                         $time, got.status, got.data);
                return;
            end
            want = due_results.pop_front();
            n_checked++;
            check_field("status", want.status, got.status);
            check_field("data_out", want.data, got.data);
            check_field("last_out", want.last, got.last);
            check_field("used_bytes", want.used, got.used);
            check_field("free_bytes", want.free, got.free);
            check_field("contig_free", want.cfree, got.cfree);
            check_field("contig_used", want.cused, got.cused);
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_valid;
    logic [IN_TDATA_W-1:0]  s_data;
    logic [REQ_W-1:0]       s_user;
    logic                   s_last;
    logic                   o_s_axis_tready;
    logic                   o_m_axis_tvalid;
    logic                   m_ready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [STAT_W-1:0]      o_m_axis_tuser;
    logic                   o_m_axis_tlast;

    t_ring_mirror ring = new();
    int unsigned  tx_idle_pct;
    int unsigned  rx_idle_pct;
    int unsigned  n_sent;
    int unsigned  idle_cycles;

    byte_ring_buffer #(
        .SLOTS(RING_SLOTS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),           // data_in[7:0], length[14:8], zero pad
        .i_s_axis_tuser  (s_user),           // req_type[2:0]
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // data_out[7:0], used_bytes[17:8],
                                             // free_bytes[27:18], contig_free[38:28],
                                             // contig_used[48:39], zero pad
        .o_m_axis_tuser  (o_m_axis_tuser),   // status[1:0]
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // receiver stalls at random
    always @(negedge i_clk) begin
        m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // check every result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_ready)
            ring.compare_result({o_m_axis_tuser, o_m_axis_tdata[7:0], o_m_axis_tlast,
                                 o_m_axis_tdata[17:8], o_m_axis_tdata[27:18],
                                 o_m_axis_tdata[38:28], o_m_axis_tdata[48:39]});
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("byte_ring_buffer regression: fail");
                $finish;
            end
        end
    end

    // present one request and wait for its transfer
    task automatic send_req(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] data_val,
                            input logic [LEN_W-1:0] len, input logic last_flag);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {1'b0, len, data_val};
        s_user  <= req;
        s_last  <= last_flag;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        ring.apply_request(req, data_val, len, last_flag);
        n_sent++;
    endtask

    // random mix, mostly whole messages and reads of stored bytes
    task automatic run_random(input int unsigned count);
        int unsigned start;
        int unsigned pick;
        int unsigned len;
        int unsigned n_bytes;
        int unsigned span;
        int unsigned used;
        int unsigned k;
        start = n_sent;
        while (n_sent - start < count) begin
            pick = $urandom_range(0, 99);
            used = ring.used_size();
            if (pick < 48) begin
                // message length: mostly small, some large, some refused
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    len = $urandom_range(1, 12);
                else if (pick < 85)
                    len = $urandom_range(13, MAX_LEN);
                else if (pick < 93)
                    len = (ring.free_size() < MAX_LEN) ?
                          $urandom_range(ring.free_size() + 1, MAX_LEN) :
                          $urandom_range(MAX_LEN + 1, 127);
                else
                    len = 0;
                n_bytes = (len > MAX_LEN) ? $urandom_range(1, 3) : len;
                if (n_bytes == 0)
                    n_bytes = 1;
                // broken shapes: short, extra bytes, left open
                pick = $urandom_range(0, 99);
                if (pick < 10 && n_bytes > 1)
                    n_bytes = $urandom_range(1, n_bytes - 1);
                else if (pick >= 10 && pick < 18)
                    n_bytes += $urandom_range(1, 3);
                for (k = 0; k < n_bytes; k++)
                    send_req(REQ_WRITE, DATA_W'($urandom_range(0, 255)),
                             LEN_W'((k == 0) ? len : $urandom_range(0, 127)),
                             (pick < 90) && (k + 1 == n_bytes));
            end else if (pick < 83) begin
                pick = $urandom_range(0, 99);
                if (pick < 80 && used > 0)
                    len = $urandom_range(1, (used < MAX_LEN) ? used : MAX_LEN);
                else
                    len = $urandom_range(0, 127);
                // keep a served read inside entries written since reset
                if (len <= MAX_LEN && len <= used) begin
                    span = 0;
                    while (span < len &&
                           ring.written[SLOT_AW'((ring.rd_pos + span) % RING_SLOTS)])
                        span++;
                    len = span;
                end
                send_req($urandom_range(0, 1) ? REQ_READ : REQ_PEEK,
                         DATA_W'($urandom_range(0, 255)), LEN_W'(len),
                         1'($urandom_range(0, 1)));
            end else if (pick < 88) begin
                len = $urandom_range(0, 1) ? $urandom_range(0, (used < 127) ? used : 127) :
                                             $urandom_range(0, 127);
                send_req(REQ_REMOVE, DATA_W'($urandom_range(0, 255)), LEN_W'(len),
                         1'($urandom_range(0, 1)));
            end else if (pick < 92) begin
                send_req(REQ_COMMIT, DATA_W'($urandom_range(0, 255)),
                         LEN_W'($urandom_range(0, 16)), 1'($urandom_range(0, 1)));
            end else if (pick < 96) begin
                send_req(REQ_CLEAR, DATA_W'($urandom_range(0, 255)),
                         LEN_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
            end else begin
                send_req($urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B,
                         DATA_W'($urandom_range(0, 255)), LEN_W'($urandom_range(0, 127)),
                         1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        s_user      = '0;
        s_last      = 1'b0;
        m_ready     = 1'b0;
        n_sent      = 0;
        idle_cycles = 0;
        tx_idle_pct = 15;
        rx_idle_pct = 57;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty store, extremes of fields, every request
        send_req(REQ_CLEAR, 8'h00, 7'd0, 1'b0);
        send_req(REQ_READ, 8'h00, 7'd0, 1'b0);
        send_req(REQ_PEEK, 8'hFF, 7'd1, 1'b1);
        send_req(REQ_WRITE, 8'h00, 7'd3, 1'b0);
        send_req(REQ_WRITE, 8'hFF, 7'd0, 1'b0);
        send_req(REQ_WRITE, 8'hA5, 7'd127, 1'b1);
        send_req(REQ_PEEK, 8'h00, 7'd3, 1'b0);
        send_req(REQ_READ, 8'h00, LEN_W'(MAX_LEN), 1'b0);
        send_req(REQ_READ, 8'h00, 7'd3, 1'b0);
        // message longer than the largest length
        send_req(REQ_WRITE, 8'h5A, 7'd127, 1'b1);
        // short message still commits its full length
        send_req(REQ_WRITE, 8'h11, 7'd5, 1'b0);
        send_req(REQ_WRITE, 8'h22, 7'd0, 1'b1);
        send_req(REQ_READ, 8'h00, 7'd2, 1'b0);
        // bytes past the message length are dropped
        send_req(REQ_WRITE, 8'h33, 7'd1, 1'b0);
        send_req(REQ_WRITE, 8'h44, 7'd1, 1'b0);
        send_req(REQ_WRITE, 8'h55, 7'd1, 1'b1);
        // message cut off by a remove
        send_req(REQ_WRITE, 8'h66, 7'd4, 1'b0);
        send_req(REQ_WRITE, 8'h77, 7'd4, 1'b0);
        send_req(REQ_REMOVE, 8'h00, 7'd3, 1'b1);
        send_req(REQ_PEEK, 8'h00, 7'd1, 1'b0);
        send_req(REQ_WRITE, 8'h88, 7'd0, 1'b1);
        send_req(REQ_SPARE_A, 8'hFF, 7'd127, 1'b1);
        send_req(REQ_SPARE_B, 8'h00, 7'd64, 1'b0);
        // full store, refused write, commit past the empty slot
        send_req(REQ_CLEAR, 8'h00, 7'd0, 1'b0);
        send_req(REQ_REMOVE, 8'h00, 7'd1, 1'b0);
        send_req(REQ_WRITE, 8'h99, 7'd1, 1'b1);
        send_req(REQ_COMMIT, 8'h00, 7'd2, 1'b0);

        // random, three idling mixes
        run_random(83);
        tx_idle_pct = 57;
        rx_idle_pct = 15;
        run_random(82);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(82);

        @(negedge i_clk);
        s_valid <= 1'b0;
        while (ring.due_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests (directed, then three idling mixes), %0d results checked",
                 ring.n_requests, ring.n_checked);
        $display("refused message bytes %0d, reads short of data %0d, mismatches %0d",
                 ring.n_no_space, ring.n_no_data, ring.n_errors);
        if (ring.n_errors == 0)
            $display("byte_ring_buffer regression: pass");
        else
            $display("byte_ring_buffer regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/brb_pkg.sv
hdl/brb_ram.sv
hdl/brb_ctrl.sv
hdl/brb_dp.sv
hdl/byte_ring_buffer.sv
sim/byte_ring_buffer_test.sv
